[src/etdu_pkg.sv]
// shared types and constants of the data tape unit
package etdu_pkg;

  // request codes
  localparam logic [2:0] REQ_RIGHT  = 3'd0;
  localparam logic [2:0] REQ_LEFT   = 3'd1;
  localparam logic [2:0] REQ_ADD    = 3'd2;
  localparam logic [2:0] REQ_SUB    = 3'd3;
  localparam logic [2:0] REQ_OUTPUT = 3'd4;
  localparam logic [2:0] REQ_INPUT  = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_UNDER  = 3'd1;
  localparam logic [2:0] ST_BEYOND = 3'd2;
  localparam logic [2:0] ST_SCALAR = 3'd3;
  localparam logic [2:0] ST_BIG    = 3'd4;

  // register map (word index taken from paddr[2])
  localparam logic CFG_IDX_WRAP_MAX = 1'b0;
  localparam logic [31:0] WRAP_MAX_RESET = 32'd255;

  // unicode scalar limits
  localparam logic [31:0] SCALAR_MAX = 32'h0010_FFFF;
  localparam logic [31:0] SURR_LO    = 32'h0000_D800;
  localparam logic [31:0] SURR_HI    = 32'h0000_DFFF;

  // control sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_EXEC  = 5'b00100,
    S_MOD   = 5'b01000,
    S_FIX   = 5'b10000
  } state_t;

endpackage

[src/etdu_mod.sv]
// bit-serial remainder unit: x mod m, one quotient bit per cycle
module etdu_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x,
  input  logic [32:0] m,
  output logic        done,
  output logic [31:0] rem
);

  logic        running;
  logic [4:0]  cnt;
  logic [31:0] x_sh;
  logic [32:0] m_r;
  logic [32:0] trial;
  logic [32:0] rem_next;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem, x_sh[31]};
    if (trial >= m_r) begin
      rem_next = trial - m_r;
    end else begin
      rem_next = trial;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && !start && (cnt == 5'd31);
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x_sh <= x;
      m_r  <= m;
      rem  <= '0;
    end else if (running) begin
      x_sh <= {x_sh[30:0], 1'b0};
      rem  <= rem_next[31:0];
    end
  end

endmodule

[src/etdu_tape.sv]
// tape memory with one read and one write port and a clearing sweep after reset
module etdu_tape #(
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  output logic          ready
);

  logic [31:0]   mem [DEPTH];
  logic          clr_active;
  logic [AW-1:0] clr_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  // clearing sweep has the write port while it runs
  always_comb begin
    if (clr_active) begin
      we = 1'b1;
      wa = clr_addr;
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  assign ready = !clr_active;

  // sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/esoteric_tape_data_unit_top.sv]
// top level of the data tape unit: sequencer, head, config register
// moves, output, input and unused codes: strobe after the fetch and execute steps, next start then
// add and subtract: strobe after fetch, execute, two 32-step serial remainders and the fix-up
// one word in flight at a time; busy stays high until its result strobe is issued
// after reset the tape is swept to zero, one cell a cycle, across all TAPE_DEPTH cells
// results cannot be stalled: done marks each word for exactly one cycle
module esoteric_tape_data_unit_top #(
  parameter int unsigned TAPE_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [31:0] operand,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] cell_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(TAPE_DEPTH);

  etdu_pkg::state_t state;
  logic [2:0]    req;
  logic [31:0]   n;
  logic [AW-1:0] head;
  logic [31:0]   wrap_max;
  logic [2:0]    stat;
  logic [32:0]   m;
  logic          accept;
  logic          tape_ready;
  logic [31:0]   rd_data;
  logic          wr_en;
  logic [31:0]   wr_data;
  logic          mod_start;
  logic          done_a;
  logic          done_b;
  logic [31:0]   rem_a;
  logic [31:0]   rem_b;
  logic [32:0]   sum;
  logic [31:0]   fix_val;
  logic          bad_scalar;
  logic          in_ok;
  logic          move_beyond;
  logic          move_under;
  logic          exec_last;
  logic [2:0]    exec_status;
  logic [31:0]   exec_value;

  assign m      = {1'b0, wrap_max} + 33'd1;
  assign busy   = (state != etdu_pkg::S_IDLE) || !tape_ready;
  assign accept = start && !busy;
  assign pready = 1'b1;

  // config register read
  always_comb begin
    if (paddr[2] == etdu_pkg::CFG_IDX_WRAP_MAX) begin
      prdata = wrap_max;
    end else begin
      prdata = '0;
    end
  end

  // config register write
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_max <= etdu_pkg::WRAP_MAX_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == etdu_pkg::CFG_IDX_WRAP_MAX) begin
      wrap_max <= pwdata;
    end
  end

  // head move range checks
  assign move_beyond = ({1'b0, 32'(head)} + {1'b0, operand}) > 33'(TAPE_DEPTH - 1);
  assign move_under  = operand > 32'(head);

  // cell checks and residue fix-up
  assign bad_scalar = (rd_data > etdu_pkg::SCALAR_MAX) ||
                      (rd_data >= etdu_pkg::SURR_LO && rd_data <= etdu_pkg::SURR_HI);
  assign in_ok      = (n <= wrap_max);

  always_comb begin
    if (req == etdu_pkg::REQ_ADD) begin
      sum = {1'b0, rem_a} + {1'b0, rem_b};
      if (sum >= m) begin
        sum = sum - m;
      end
    end else begin
      if (rem_a >= rem_b) begin
        sum = {1'b0, rem_a} - {1'b0, rem_b};
      end else begin
        sum = {1'b0, rem_a} + m - {1'b0, rem_b};
      end
    end
    fix_val = sum[31:0];
  end

  // tape write port
  always_comb begin
    wr_en   = 1'b0;
    wr_data = fix_val;
    if (state == etdu_pkg::S_FIX) begin
      wr_en = 1'b1;
    end else if (state == etdu_pkg::S_EXEC && req == etdu_pkg::REQ_INPUT && in_ok) begin
      wr_en   = 1'b1;
      wr_data = n;
    end
  end

  assign mod_start = (state == etdu_pkg::S_EXEC) &&
                     (req == etdu_pkg::REQ_ADD || req == etdu_pkg::REQ_SUB);
  assign exec_last = (state == etdu_pkg::S_EXEC) && !mod_start;

  // result of a single-step word
  always_comb begin
    exec_status = stat;
    exec_value  = rd_data;
    if (req == etdu_pkg::REQ_OUTPUT && bad_scalar) begin
      exec_status = etdu_pkg::ST_SCALAR;
    end else if (req == etdu_pkg::REQ_INPUT) begin
      if (in_ok) begin
        exec_value = n;
      end else begin
        exec_status = etdu_pkg::ST_BIG;
      end
    end
  end

  // sequencer and head
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etdu_pkg::S_IDLE;
      head  <= '0;
    end else begin
      case (state)
        etdu_pkg::S_IDLE: begin
          if (accept) begin
            req   <= req_type;
            n     <= operand;
            state <= etdu_pkg::S_FETCH;
            if (req_type == etdu_pkg::REQ_RIGHT && move_beyond) begin
              stat <= etdu_pkg::ST_BEYOND;
            end else if (req_type == etdu_pkg::REQ_LEFT && move_under) begin
              stat <= etdu_pkg::ST_UNDER;
            end else begin
              stat <= etdu_pkg::ST_OK;
            end
            if (req_type == etdu_pkg::REQ_RIGHT && !move_beyond) begin
              head <= head + operand[AW-1:0];
            end else if (req_type == etdu_pkg::REQ_LEFT && !move_under) begin
              head <= head - operand[AW-1:0];
            end
          end
        end
        etdu_pkg::S_FETCH: begin
          state <= etdu_pkg::S_EXEC;
        end
        etdu_pkg::S_EXEC: begin
          if (mod_start) begin
            state <= etdu_pkg::S_MOD;
          end else begin
            state <= etdu_pkg::S_IDLE;
          end
        end
        etdu_pkg::S_MOD: begin
          if (done_a && done_b) begin
            state <= etdu_pkg::S_FIX;
          end
        end
        etdu_pkg::S_FIX: begin
          state <= etdu_pkg::S_IDLE;
        end
        default: begin
          state <= etdu_pkg::S_IDLE;
        end
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exec_last || (state == etdu_pkg::S_FIX);
      if (exec_last) begin
        status     <= exec_status;
        cell_value <= exec_value;
      end else if (state == etdu_pkg::S_FIX) begin
        status     <= etdu_pkg::ST_OK;
        cell_value <= fix_val;
      end
    end
  end

  // tape memory
  etdu_tape #(
    .DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (state == etdu_pkg::S_FETCH),
    .rd_addr (head),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (head),
    .wr_data (wr_data),
    .ready   (tape_ready)
  );

  // residue of the current cell
  etdu_mod u_mod_cell (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .x     (rd_data),
    .m     (m),
    .done  (done_a),
    .rem   (rem_a)
  );

  // residue of the count
  etdu_mod u_mod_cnt (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .x     (n),
    .m     (m),
    .done  (done_b),
    .rem   (rem_b)
  );

  // head never leaves the tape
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    32'(head) <= 32'(TAPE_DEPTH - 1))
    else $error("head beyond tape end");

  // result word only leaves from the execute or fix-up step
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == etdu_pkg::S_EXEC || $past(state) == etdu_pkg::S_FIX))
    else $error("result strobe from wrong state");

  // both remainder units finish together and only while waiting on them
  a_mod_sync: assert property (@(posedge clk) disable iff (rst)
    (done_a || done_b) |-> (done_a && done_b && state == etdu_pkg::S_MOD))
    else $error("remainder units out of step");

  // no sequencer write while the clearing sweep runs
  a_no_wr_clear: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> tape_ready)
    else $error("tape write during clearing sweep");

  // one word at a time: strobes never back to back
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back to back result strobes");

endmodule

[test/testbench.sv]
// testbench for the data tape unit: directed table, random phases, predictor check
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TAPE_DEPTH  = 65536;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 180;

  // request codes with no operation behind them
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  // byte addresses of the register map
  localparam logic [2:0] ADDR_WRAP_MAX = {etdu_pkg::CFG_IDX_WRAP_MAX, 2'b00};
  localparam logic [2:0] ADDR_SPARE    = 3'd4;

  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] val;
  } tape_word_t;

  // one row of the directed table: a register write or a word to issue
  typedef struct {
    bit          cfg;
    logic [2:0]  addr;
    logic [2:0]  rq;
    logic [31:0] op;
    bit          typed;
    logic [2:0]  st;
    logic [31:0] val;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  req_type = etdu_pkg::REQ_OUTPUT;
  logic [31:0] operand = 32'd0;
  logic        done;
  logic [2:0]  status;
  logic [31:0] cell_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [31:0] tape_cells [TAPE_DEPTH];
  logic [31:0] head_pos;
  logic [31:0] wrap_max_cfg;
  tape_word_t  words_due [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  step_row_t dir_rows [31] = '{
    '{0, 3'd0, etdu_pkg::REQ_OUTPUT, 32'd0,         1, etdu_pkg::ST_OK,     32'd0},
    '{0, 3'd0, etdu_pkg::REQ_LEFT,   32'd1,         1, etdu_pkg::ST_UNDER,  32'd0},
    '{0, 3'd0, etdu_pkg::REQ_SUB,    32'd1,         1, etdu_pkg::ST_OK,     32'd255},
    '{0, 3'd0, etdu_pkg::REQ_ADD,    32'hFFFF_FFFF, 1, etdu_pkg::ST_OK,     32'd254},
    '{0, 3'd0, etdu_pkg::REQ_INPUT,  32'd256,       1, etdu_pkg::ST_BIG,    32'd254},
    '{0, 3'd0, etdu_pkg::REQ_INPUT,  32'd255,       1, etdu_pkg::ST_OK,     32'd255},
    '{0, 3'd0, etdu_pkg::REQ_RIGHT,  32'd65535,     1, etdu_pkg::ST_OK,     32'd0},
    '{0, 3'd0, etdu_pkg::REQ_RIGHT,  32'd1,         1, etdu_pkg::ST_BEYOND, 32'd0},
    '{0, 3'd0, etdu_pkg::REQ_INPUT,  32'd7,         1, etdu_pkg::ST_OK,     32'd7},
    '{0, 3'd0, etdu_pkg::REQ_LEFT,   32'd65535,     1, etdu_pkg::ST_OK,     32'd255},
    '{0, 3'd0, etdu_pkg::REQ_LEFT,   32'hFFFF_FFFF, 1, etdu_pkg::ST_UNDER,  32'd255},
    '{0, 3'd0, REQ_SPARE6,           32'h5A5A_A5A5, 1, etdu_pkg::ST_OK,     32'd255},
    '{0, 3'd0, REQ_SPARE7,           32'd0,         1, etdu_pkg::ST_OK,     32'd255},
    '{1, ADDR_WRAP_MAX, etdu_pkg::REQ_OUTPUT, 32'hFFFF_FFFF, 0, etdu_pkg::ST_OK, 32'd0},
    '{0, 3'd0, etdu_pkg::REQ_INPUT,  32'hFFFF_FFFF, 1, etdu_pkg::ST_OK,     32'hFFFF_FFFF},
    '{0, 3'd0, etdu_pkg::REQ_OUTPUT, 32'd0,         1, etdu_pkg::ST_SCALAR, 32'hFFFF_FFFF},
    '{0, 3'd0, etdu_pkg::REQ_ADD,    32'd1,         1, etdu_pkg::ST_OK,     32'd0},
    '{0, 3'd0, etdu_pkg::REQ_INPUT,  etdu_pkg::SURR_LO, 1, etdu_pkg::ST_OK,
      etdu_pkg::SURR_LO},
    '{0, 3'd0, etdu_pkg::REQ_OUTPUT, 32'd0,         1, etdu_pkg::ST_SCALAR,
      etdu_pkg::SURR_LO},
    '{0, 3'd0, etdu_pkg::REQ_INPUT,  etdu_pkg::SURR_HI, 1, etdu_pkg::ST_OK,
      etdu_pkg::SURR_HI},
    '{0, 3'd0, etdu_pkg::REQ_OUTPUT, 32'hFFFF_FFFF, 1, etdu_pkg::ST_SCALAR,
      etdu_pkg::SURR_HI},
    '{0, 3'd0, etdu_pkg::REQ_INPUT,  etdu_pkg::SCALAR_MAX, 1, etdu_pkg::ST_OK,
      etdu_pkg::SCALAR_MAX},
    '{0, 3'd0, etdu_pkg::REQ_OUTPUT, 32'd0,         1, etdu_pkg::ST_OK,
      etdu_pkg::SCALAR_MAX},
    '{1, ADDR_WRAP_MAX, etdu_pkg::REQ_OUTPUT, 32'd1, 0, etdu_pkg::ST_OK, 32'd0},
    '{0, 3'd0, etdu_pkg::REQ_ADD,    32'd0,         0, etdu_pkg::ST_OK,     32'd0},
    '{0, 3'd0, etdu_pkg::REQ_INPUT,  32'd2,         1, etdu_pkg::ST_BIG,    32'd1},
    '{1, ADDR_WRAP_MAX, etdu_pkg::REQ_OUTPUT, 32'd0, 0, etdu_pkg::ST_OK, 32'd0},
    '{0, 3'd0, etdu_pkg::REQ_SUB,    32'd3,         1, etdu_pkg::ST_OK,     32'd0},
    '{1, ADDR_SPARE, etdu_pkg::REQ_OUTPUT, 32'd5,   0, etdu_pkg::ST_OK,     32'd0},
    '{0, 3'd0, etdu_pkg::REQ_INPUT,  32'd1,         1, etdu_pkg::ST_BIG,    32'd0},
    '{1, ADDR_WRAP_MAX, etdu_pkg::REQ_OUTPUT, etdu_pkg::WRAP_MAX_RESET, 0,
      etdu_pkg::ST_OK, 32'd0}
  };

  esoteric_tape_data_unit_top #(
    .TAPE_DEPTH(TAPE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .operand(operand),
    .done(done),
    .status(status),
    .cell_value(cell_value),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d: %s expected %h got %h", mismatch_count, what, want, got);
  endtask

  // apply one word to the predicted tape and return the word it produces
  function automatic tape_word_t tape_step(input logic [2:0] rq, input logic [31:0] n);
    tape_word_t  w;
    logic [63:0] m;
    logic [63:0] c;
    logic [31:0] cur;
    w.st = etdu_pkg::ST_OK;
    m = {32'd0, wrap_max_cfg} + 64'd1;
    cur = tape_cells[head_pos];
    c = {32'd0, cur} % m;
    case (rq)
      etdu_pkg::REQ_RIGHT: begin
        if ({32'd0, head_pos} + {32'd0, n} > 64'(TAPE_DEPTH - 1)) w.st = etdu_pkg::ST_BEYOND;
        else head_pos = head_pos + n;
      end
      etdu_pkg::REQ_LEFT: begin
        if (n > head_pos) w.st = etdu_pkg::ST_UNDER;
        else head_pos = head_pos - n;
      end
      etdu_pkg::REQ_ADD: tape_cells[head_pos] = 32'((c + {32'd0, n} % m) % m);
      etdu_pkg::REQ_SUB: tape_cells[head_pos] = 32'((c + m - {32'd0, n} % m) % m);
      etdu_pkg::REQ_OUTPUT: begin
        if (cur > etdu_pkg::SCALAR_MAX ||
            (cur >= etdu_pkg::SURR_LO && cur <= etdu_pkg::SURR_HI)) w.st = etdu_pkg::ST_SCALAR;
      end
      etdu_pkg::REQ_INPUT: begin
        if (n > wrap_max_cfg) w.st = etdu_pkg::ST_BIG;
        else tape_cells[head_pos] = n;
      end
      default: ;
    endcase
    w.val = tape_cells[head_pos];
    return w;
  endfunction

  // issue one word in bursts with random gaps; start stays high between back-to-back words
  task automatic issue_word(input logic [2:0] rq, input logic [31:0] op,
                            input bit typed, input tape_word_t typed_w);
    tape_word_t  pred;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    start <= 1'b1;
    req_type <= rq;
    operand <= op;
    do @(posedge clk); while (busy !== 1'b0);
    pred = tape_step(rq, op);
    words_due.push_back(typed ? typed_w : pred);
    burst_left--;
  endtask

  // stop issuing and wait until every due word has come back
  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    while (words_due.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // bus write followed by a read-back of wrap_max
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (addr == ADDR_WRAP_MAX) wrap_max_cfg = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_WRAP_MAX;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== wrap_max_cfg) report_mismatch("wrap_max read", wrap_max_cfg, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // random word shaped by the current head and wrap_max
  task automatic pick_word(output logic [2:0] rq, output logic [31:0] op);
    int unsigned kind;
    int unsigned sel;
    kind = $urandom_range(0, 19);
    sel = $urandom_range(0, 9);
    op = $urandom;
    if (kind <= 5) begin
      rq = (kind <= 2) ? etdu_pkg::REQ_RIGHT : etdu_pkg::REQ_LEFT;
      case (sel)
        0, 1, 2, 3, 4, 5: op = $urandom_range(0, 32);
        6: op = $urandom;
        7: op = (rq == etdu_pkg::REQ_RIGHT) ? TAPE_DEPTH - 1 - head_pos : head_pos;
        8: op = (rq == etdu_pkg::REQ_RIGHT) ? TAPE_DEPTH - head_pos : head_pos + 1;
        default: op = $urandom_range(0, 4095);
      endcase
    end else if (kind <= 11) begin
      rq = (kind <= 8) ? etdu_pkg::REQ_ADD : etdu_pkg::REQ_SUB;
      case (sel)
        0, 1, 2, 3: op = $urandom_range(0, 16);
        4, 5, 6: op = $urandom;
        7: op = wrap_max_cfg;
        8: op = wrap_max_cfg + 32'd1;
        default: op = $urandom_range(0, wrap_max_cfg);
      endcase
    end else if (kind <= 14) begin
      rq = etdu_pkg::REQ_OUTPUT;
    end else if (kind <= 18) begin
      rq = etdu_pkg::REQ_INPUT;
      case (sel)
        0, 1, 2, 3, 4, 5: op = $urandom_range(0, wrap_max_cfg);
        6: op = wrap_max_cfg;
        7: op = (wrap_max_cfg == 32'hFFFF_FFFF) ? $urandom : wrap_max_cfg + 32'd1;
        8: begin
          case ($urandom_range(0, 5))
            0: op = etdu_pkg::SURR_LO - 32'd1;
            1: op = etdu_pkg::SURR_LO;
            2: op = etdu_pkg::SURR_HI;
            3: op = etdu_pkg::SURR_HI + 32'd1;
            4: op = etdu_pkg::SCALAR_MAX;
            default: op = etdu_pkg::SCALAR_MAX + 32'd1;
          endcase
        end
        default: op = $urandom;
      endcase
    end else begin
      rq = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
    end
  endtask

  // check each result word against the oldest one due
  always @(posedge clk) begin : check_words
    tape_word_t w;
    if (!rst && done === 1'b1) begin
      if (words_due.size() == 0) begin
        report_mismatch("word with nothing due", 32'd0, cell_value);
      end else begin
        w = words_due.pop_front();
        if (status !== w.st) report_mismatch("status", {29'd0, w.st}, {29'd0, status});
        if (cell_value !== w.val) report_mismatch("cell_value", w.val, cell_value);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [31:0] phase_max [7];
    logic [2:0]  rq;
    logic [31:0] op;
    tape_word_t  tw;
    foreach (tape_cells[i]) tape_cells[i] = 32'd0;
    head_pos = 32'd0;
    wrap_max_cfg = etdu_pkg::WRAP_MAX_RESET;
    phase_max = '{etdu_pkg::WRAP_MAX_RESET, 32'd1, 32'hFFFF_FFFF, $urandom,
                  etdu_pkg::SCALAR_MAX, 32'd0, $urandom_range(2, 1000)};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // tape sweep after reset keeps busy high
    settle();

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) begin
        settle();
        write_reg(dir_rows[i].addr, dir_rows[i].op);
      end else begin
        tw.st = dir_rows[i].st;
        tw.val = dir_rows[i].val;
        issue_word(dir_rows[i].rq, dir_rows[i].op, dir_rows[i].typed, tw);
      end
    end

    // random phases, one wrap_max setting each
    foreach (phase_max[p]) begin
      settle();
      write_reg(ADDR_WRAP_MAX, phase_max[p]);
      repeat (ITEMS_PER_PHASE) begin
        pick_word(rq, op);
        issue_word(rq, op, 1'b0, '0);
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
